// File: hw/rtl/e2c_pkg.sv
// Shared constants, types and helper functions for the epoch-to-calendar converter.
package e2c_pkg;

  localparam int unsigned EPOCH_W   = 32;
  localparam int unsigned DIV_BITS  = 8;
  localparam int unsigned DIV_CYC   = EPOCH_W / DIV_BITS;
  localparam int unsigned DIV_CNT_W = $clog2(DIV_CYC);
  localparam int unsigned REM_W     = 6;
  localparam int unsigned DAY_W     = 16;
  localparam int unsigned YDAY_W    = 9;
  localparam int unsigned YEAR_W    = 8;
  localparam int unsigned MON_W     = 4;
  localparam int unsigned MDAY_W    = 5;
  localparam int unsigned WDAY_W    = 3;
  localparam int unsigned HOUR_W    = 5;

  localparam logic [REM_W-1:0]  SecsPerMin   = 6'd60;
  localparam logic [REM_W-1:0]  HoursPerDay  = 6'd24;
  localparam logic [YEAR_W-1:0] EpochYear    = 8'd70;   // 1970 - 1900
  localparam logic [YEAR_W-1:0] Year1900     = 8'd0;
  localparam logic [YEAR_W-1:0] Year2100     = 8'd200;
  localparam logic [WDAY_W-1:0] EpochWeekday = 3'd4;    // Thursday
  localparam logic [WDAY_W-1:0] DaysPerWeek  = 3'd7;
  localparam logic [MON_W-1:0]  MonthJan     = 4'd0;
  localparam logic [MON_W-1:0]  MonthFeb     = 4'd1;
  localparam logic [MON_W-1:0]  MonthDec     = 4'd11;
  localparam logic [YDAY_W-1:0] DaysLeap     = 9'd366;
  localparam logic [YDAY_W-1:0] DaysCommon   = 9'd365;
  localparam logic [MDAY_W-1:0] DaysFourWeek = 5'd28;

  typedef enum logic [1:0] {
    DIV_SEC,
    DIV_MIN,
    DIV_HOUR
  } div_sel_e;

  typedef struct packed {
    logic     load;
    logic     div_step;
    logic     div_last;
    div_sel_e div_sel;
    logic     year_step;
    logic     month_step;
    logic     out_load;
  } cmd_t;

  typedef struct packed {
    logic year_done;
    logic month_done;
  } sts_t;

  // Gregorian leap test on a year offset from 1900
  function automatic logic is_leap(input logic [YEAR_W-1:0] y);
    return (y[1:0] == 2'd0) && (y != Year1900) && (y != Year2100);
  endfunction

  function automatic logic [MDAY_W-1:0] month_len(input logic [MON_W-1:0] m,
                                                  input logic leap);
    logic [MDAY_W-1:0] len;
    unique case (m)
      4'd0, 4'd2, 4'd4, 4'd6, 4'd7, 4'd9, 4'd11: len = 5'd31;
      4'd3, 4'd5, 4'd8, 4'd10:                  len = 5'd30;
      MonthFeb:                                 len = leap ? 5'd29 : 5'd28;
      default:                                  len = 5'd31;
    endcase
    return len;
  endfunction

  // (w + inc) mod 7 for w < 7, inc < 4
  function automatic logic [WDAY_W-1:0] wday_add(input logic [WDAY_W-1:0] w,
                                                 input logic [1:0] inc);
    logic [WDAY_W:0] s;
    s = {1'b0, w} + {2'b00, inc};
    if (s >= {1'b0, DaysPerWeek}) begin
      s = s - {1'b0, DaysPerWeek};
    end
    return s[WDAY_W-1:0];
  endfunction

  // v mod 7 for v < 42
  function automatic logic [WDAY_W-1:0] wday_fold(input logic [5:0] v);
    logic [5:0] t;
    t = v;
    for (int i = 0; i < 5; i++) begin
      if (t >= {3'b000, DaysPerWeek}) begin
        t = t - {3'b000, DaysPerWeek};
      end
    end
    return t[WDAY_W-1:0];
  endfunction

endpackage

// File: hw/rtl/e2c_datapath.sv
// Datapath: radix-256 constant divider, year and month walk, result registers.
module e2c_datapath (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  e2c_pkg::cmd_t                      cmd_i,
  output e2c_pkg::sts_t                      sts_o,
  input  logic [e2c_pkg::EPOCH_W-1:0]        epoch_seconds_i,
  output logic [5:0]                         second_o,
  output logic [5:0]                         minute_o,
  output logic [e2c_pkg::HOUR_W-1:0]         hour_o,
  output logic [e2c_pkg::MDAY_W-1:0]         day_of_month_o,
  output logic [e2c_pkg::MON_W-1:0]          month_o,
  output logic [e2c_pkg::YEAR_W-1:0]         years_since_1900_o,
  output logic [e2c_pkg::WDAY_W-1:0]         weekday_o,
  output logic [e2c_pkg::YDAY_W-1:0]         day_of_year_o
);

  logic [e2c_pkg::EPOCH_W-1:0] n_q, n_d;
  logic [e2c_pkg::REM_W-1:0]   r_q, r_d, dv;
  logic [e2c_pkg::REM_W-1:0]   sec_q, min_q, hr_q;
  logic [e2c_pkg::DAY_W-1:0]   days_q;
  logic [e2c_pkg::YEAR_W-1:0]  year_q;
  logic [e2c_pkg::WDAY_W-1:0]  wday_q;
  logic [e2c_pkg::YDAY_W-1:0]  yday_q;
  logic [e2c_pkg::MON_W-1:0]   mon_q;
  logic                        leap_q;
  logic                        year_leap;
  logic [e2c_pkg::YDAY_W-1:0]  ylen;
  logic [e2c_pkg::MDAY_W-1:0]  mlen;
  logic [1:0]                  minc;

  assign dv = (cmd_i.div_sel == e2c_pkg::DIV_HOUR) ? e2c_pkg::HoursPerDay
                                                   : e2c_pkg::SecsPerMin;

  always_comb begin
    logic [e2c_pkg::EPOCH_W-1:0] n;
    logic [e2c_pkg::REM_W:0]     t;
    logic [e2c_pkg::REM_W-1:0]   r;
    n = n_q;
    r = r_q;
    for (int i = 0; i < int'(e2c_pkg::DIV_BITS); i++) begin
      t = {r, n[e2c_pkg::EPOCH_W-1]};
      n = {n[e2c_pkg::EPOCH_W-2:0], 1'b0};
      if (t >= {1'b0, dv}) begin
        t    = t - {1'b0, dv};
        n[0] = 1'b1;
      end
      r = t[e2c_pkg::REM_W-1:0];
    end
    n_d = n;
    r_d = r;
  end

  assign year_leap = e2c_pkg::is_leap(year_q);
  assign ylen      = year_leap ? e2c_pkg::DaysLeap : e2c_pkg::DaysCommon;
  assign mlen      = e2c_pkg::month_len(mon_q, leap_q);
  assign minc      = 2'(mlen - e2c_pkg::DaysFourWeek);

  assign sts_o.year_done  = days_q < {{(e2c_pkg::DAY_W-e2c_pkg::YDAY_W){1'b0}}, ylen};
  assign sts_o.month_done = (days_q < {{(e2c_pkg::DAY_W-e2c_pkg::MDAY_W){1'b0}}, mlen})
                            || (mon_q == e2c_pkg::MonthDec);

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      n_q <= epoch_seconds_i;
      r_q <= '0;
    end else if (cmd_i.div_step) begin
      n_q <= n_d;
      r_q <= cmd_i.div_last ? '0 : r_d;
      if (cmd_i.div_last) begin
        unique case (cmd_i.div_sel)
          e2c_pkg::DIV_SEC: sec_q <= r_d;
          e2c_pkg::DIV_MIN: min_q <= r_d;
          e2c_pkg::DIV_HOUR: begin
            hr_q   <= r_d;
            days_q <= n_d[e2c_pkg::DAY_W-1:0];
            year_q <= e2c_pkg::EpochYear;
            wday_q <= e2c_pkg::EpochWeekday;
          end
          default: sec_q <= r_d;
        endcase
      end
    end
    if (cmd_i.year_step) begin
      if (sts_o.year_done) begin
        yday_q <= days_q[e2c_pkg::YDAY_W-1:0];
        mon_q  <= e2c_pkg::MonthJan;
        leap_q <= year_leap;
      end else begin
        days_q <= days_q - {{(e2c_pkg::DAY_W-e2c_pkg::YDAY_W){1'b0}}, ylen};
        year_q <= year_q + 8'd1;
        wday_q <= e2c_pkg::wday_add(wday_q, year_leap ? 2'd2 : 2'd1);
      end
    end
    if (cmd_i.month_step && !sts_o.month_done) begin
      days_q <= days_q - {{(e2c_pkg::DAY_W-e2c_pkg::MDAY_W){1'b0}}, mlen};
      mon_q  <= mon_q + 4'd1;
      wday_q <= e2c_pkg::wday_add(wday_q, minc);
    end
    if (cmd_i.out_load) begin
      second_o           <= sec_q;
      minute_o           <= min_q;
      hour_o             <= hr_q[e2c_pkg::HOUR_W-1:0];
      day_of_month_o     <= days_q[e2c_pkg::MDAY_W-1:0] + 5'd1;
      month_o            <= mon_q;
      years_since_1900_o <= year_q;
      weekday_o          <= e2c_pkg::wday_fold({3'b000, wday_q} + {1'b0, days_q[4:0]});
      day_of_year_o      <= yday_q;
    end
  end

  a_rem_below_divisor: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.div_step |-> r_q < dv)
    else $error("divider remainder out of range");

  a_year_advance: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.year_step && !sts_o.year_done) |=> year_q == $past(year_q) + 8'd1)
    else $error("year walk did not advance");

  a_month_fits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.out_load |-> (mon_q <= e2c_pkg::MonthDec) && (days_q < 16'd31))
    else $error("month walk overran");

endmodule

// File: hw/rtl/e2c_ctrl.sv
// Controller: sequences the divisions, the year and month walks and the output handoff.
module e2c_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  input  e2c_pkg::sts_t sts_i,
  output e2c_pkg::cmd_t cmd_o
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV,
    ST_YEAR,
    ST_MONTH,
    ST_FIN
  } state_e;

  state_e                          state_q;
  logic [e2c_pkg::DIV_CNT_W-1:0]   cnt_q;
  e2c_pkg::div_sel_e               phase_q;
  logic                            out_valid_q;
  logic                            div_last;

  assign div_last    = cnt_q == e2c_pkg::DIV_CNT_W'(e2c_pkg::DIV_CYC - 1);
  assign in_stall_o  = state_q != ST_IDLE;
  assign out_valid_o = out_valid_q;

  always_comb begin
    cmd_o            = '0;
    cmd_o.div_sel    = phase_q;
    cmd_o.load       = (state_q == ST_IDLE) && in_valid_i;
    cmd_o.div_step   = state_q == ST_DIV;
    cmd_o.div_last   = (state_q == ST_DIV) && div_last;
    cmd_o.year_step  = state_q == ST_YEAR;
    cmd_o.month_step = state_q == ST_MONTH;
    cmd_o.out_load   = (state_q == ST_FIN) && (!out_valid_q || !out_stall_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      phase_q     <= e2c_pkg::DIV_SEC;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_o.out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (in_valid_i) begin
            state_q <= ST_DIV;
            cnt_q   <= '0;
            phase_q <= e2c_pkg::DIV_SEC;
          end
        end
        ST_DIV: begin
          cnt_q <= cnt_q + 1'b1;
          if (div_last) begin
            unique case (phase_q)
              e2c_pkg::DIV_SEC:  phase_q <= e2c_pkg::DIV_MIN;
              e2c_pkg::DIV_MIN:  phase_q <= e2c_pkg::DIV_HOUR;
              e2c_pkg::DIV_HOUR: state_q <= ST_YEAR;
              default:           state_q <= ST_IDLE;
            endcase
          end
        end
        ST_YEAR: begin
          if (sts_i.year_done) begin
            state_q <= ST_MONTH;
          end
        end
        ST_MONTH: begin
          if (sts_i.month_done) begin
            state_q <= ST_FIN;
          end
        end
        ST_FIN: begin
          if (cmd_o.out_load) begin
            state_q <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  a_start_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_IDLE && in_valid_i) |=>
      (state_q == ST_DIV && cnt_q == '0 && phase_q == e2c_pkg::DIV_SEC))
    else $error("request did not start the divider");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_stall_i) |-> !cmd_o.out_load)
    else $error("pending result overwritten");

  a_fin_from_month: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(state_q == ST_FIN) |-> $past(state_q) == ST_MONTH)
    else $error("finish entered out of order");

endmodule

// File: hw/rtl/epoch_to_calendar_unit.sv
// Top level of the epoch-to-calendar converter.
//
//   channel  direction  handshake              payload
//   in       request    in_valid_i/in_stall_o  epoch_seconds_i
//   out      result     out_valid_o/out_stall_i second_o .. day_of_year_o
//
// A request steps through three 32-bit constant divisions at 8 bits per cycle,
// then one year per cycle and one month per cycle, each walk subtracting from
// the same day count, then the finish step.
// Reset (rst_ni, async, active low) returns the controller to idle with no
// pending result. A new request is taken while a result waits on out_stall_i;
// the finish step then holds until the output register is free.
module epoch_to_calendar_unit (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  logic [e2c_pkg::EPOCH_W-1:0]        epoch_seconds_i,
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output logic [5:0]                         second_o,
  output logic [5:0]                         minute_o,
  output logic [e2c_pkg::HOUR_W-1:0]         hour_o,
  output logic [e2c_pkg::MDAY_W-1:0]         day_of_month_o,
  output logic [e2c_pkg::MON_W-1:0]          month_o,
  output logic [e2c_pkg::YEAR_W-1:0]         years_since_1900_o,
  output logic [e2c_pkg::WDAY_W-1:0]         weekday_o,
  output logic [e2c_pkg::YDAY_W-1:0]         day_of_year_o
);

  e2c_pkg::cmd_t cmd;
  e2c_pkg::sts_t sts;

  e2c_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  e2c_datapath u_datapath (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cmd_i              (cmd),
    .sts_o              (sts),
    .epoch_seconds_i    (epoch_seconds_i),
    .second_o           (second_o),
    .minute_o           (minute_o),
    .hour_o             (hour_o),
    .day_of_month_o     (day_of_month_o),
    .month_o            (month_o),
    .years_since_1900_o (years_since_1900_o),
    .weekday_o          (weekday_o),
    .day_of_year_o      (day_of_year_o)
  );

endmodule
